### src/fmcc_pkg.sv
package fmcc_pkg;

  localparam int unsigned SCHEDULE_SLOTS_DEFAULT = 8;
  localparam int unsigned ENTRY_W = 8;

  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd30;
  localparam logic [29:0] SINCE_MAX = 30'h3FFF_FFFF;
  localparam logic [7:0] ELAPSED_MAX = 8'hFF;
  localparam logic [2:0] NO_FED_DAY = 3'd7;
  localparam logic [4:0] NO_FED_HOUR = 5'd31;

  localparam logic [1:0] PH_ON_SWITCH = 2'd0;
  localparam logic [1:0] PH_RUNNING = 2'd1;
  localparam logic [1:0] PH_STOPPED = 2'd2;
  localparam logic [1:0] PH_DEBOUNCE = 2'd3;

  localparam logic [2:0] REG_INTERVAL_MODE_ON = 3'd0;
  localparam logic [2:0] REG_SCHEDULE_MODE_ON = 3'd1;
  localparam logic [2:0] REG_INTERVAL_HOURS = 3'd2;
  localparam logic [2:0] REG_SCHEDULE_COUNT = 3'd3;
  localparam logic [2:0] REG_SCHEDULE_TABLE = 3'd4;
  localparam logic [2:0] REG_DEBOUNCE_MS = 3'd5;

  typedef struct packed {
    logic        interval_mode_on;
    logic        schedule_mode_on;
    logic [29:0] interval_need;
    logic [3:0]  schedule_count;
    logic [7:0]  debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic       motor_run;
    logic [1:0] cycle_phase;
    logic       feed_started;
  } res_t;

endpackage

### src/fmcc_cfg.sv
module fmcc_cfg #(
  parameter int unsigned SCHEDULE_SLOTS = fmcc_pkg::SCHEDULE_SLOTS_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       wr_en,
  input  logic [2:0]                                 wr_index,
  input  logic [63:0]                                wr_data,
  output fmcc_pkg::cfg_t                             cfg,
  output logic [SCHEDULE_SLOTS*fmcc_pkg::ENTRY_W-1:0] schedule_table
);

  localparam int unsigned TableW = SCHEDULE_SLOTS * fmcc_pkg::ENTRY_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_mode_on <= 1'b0;
      cfg.schedule_mode_on <= 1'b0;
      cfg.interval_need <= '0;
      cfg.schedule_count <= '0;
      cfg.debounce_ms <= fmcc_pkg::DEBOUNCE_RESET;
      schedule_table <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        fmcc_pkg::REG_INTERVAL_MODE_ON: cfg.interval_mode_on <= wr_data[0];
        fmcc_pkg::REG_SCHEDULE_MODE_ON: cfg.schedule_mode_on <= wr_data[0];
        fmcc_pkg::REG_INTERVAL_HOURS: begin
          // precompute the threshold in ticks
          cfg.interval_need <= 30'(wr_data[7:0]) * 30'(fmcc_pkg::MS_PER_HOUR);
        end
        fmcc_pkg::REG_SCHEDULE_COUNT: cfg.schedule_count <= wr_data[3:0];
        fmcc_pkg::REG_SCHEDULE_TABLE: schedule_table <= wr_data[TableW-1:0];
        fmcc_pkg::REG_DEBOUNCE_MS: cfg.debounce_ms <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### src/fmcc_core.sv
module fmcc_core #(
  parameter int unsigned SCHEDULE_SLOTS = fmcc_pkg::SCHEDULE_SLOTS_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  fmcc_pkg::cfg_t                             cfg,
  input  logic [SCHEDULE_SLOTS*fmcc_pkg::ENTRY_W-1:0] schedule_table,
  input  logic                                       sw,
  input  logic [2:0]                                 day,
  input  logic [4:0]                                 hour,
  output fmcc_pkg::res_t                             res
);

  localparam logic [3:0] SlotCount = 4'(SCHEDULE_SLOTS);

  logic [1:0]  phase, phase_next;
  logic [29:0] since_cycle_ms, since_next;
  logic [7:0]  debounce_elapsed, elapsed_next;
  logic [2:0]  last_fed_day, last_day_next;
  logic [4:0]  last_fed_hour, last_hour_next;
  logic        drive_on, drive_next;

  logic [3:0]  slots_used;
  logic        hit;
  logic        done;
  logic        sched_start;
  logic        started;

  always_comb begin
    slots_used = (cfg.schedule_count > SlotCount) ? SlotCount : cfg.schedule_count;
    hit = 1'b0;
    for (int i = 0; i < SCHEDULE_SLOTS; i++) begin
      if (4'(i) < slots_used &&
          schedule_table[i*fmcc_pkg::ENTRY_W +: 3] == day &&
          schedule_table[i*fmcc_pkg::ENTRY_W + 3 +: 5] == hour) begin
        hit = 1'b1;
      end
    end
    done = (day == last_fed_day) && (hour == last_fed_hour);
    sched_start = cfg.schedule_mode_on && hit && !done;
  end

  always_comb begin
    phase_next = phase;
    since_next = since_cycle_ms;
    elapsed_next = debounce_elapsed;
    last_day_next = last_fed_day;
    last_hour_next = last_fed_hour;
    drive_next = drive_on;
    started = 1'b0;

    if (phase_next == fmcc_pkg::PH_STOPPED) begin
      if ((cfg.interval_mode_on && since_cycle_ms >= cfg.interval_need) || sched_start) begin
        drive_next = 1'b1;
        phase_next = fmcc_pkg::PH_RUNNING;
        started = 1'b1;
      end
      if (sched_start) begin
        last_day_next = day;
        last_hour_next = hour;
      end
    end

    if (phase_next == fmcc_pkg::PH_RUNNING && !sw) begin
      phase_next = fmcc_pkg::PH_ON_SWITCH;
    end

    if (phase_next == fmcc_pkg::PH_ON_SWITCH && sw) begin
      elapsed_next = '0;
      phase_next = fmcc_pkg::PH_DEBOUNCE;
    end

    if (phase_next == fmcc_pkg::PH_DEBOUNCE) begin
      if (elapsed_next > cfg.debounce_ms || elapsed_next == fmcc_pkg::ELAPSED_MAX) begin
        if (sw) begin
          drive_next = 1'b0;
          since_next = '0;
          phase_next = fmcc_pkg::PH_STOPPED;
        end else begin
          phase_next = fmcc_pkg::PH_ON_SWITCH;
        end
      end
    end

    // advance and saturate the tick counters
    if (since_next < fmcc_pkg::SINCE_MAX) begin
      since_next = since_next + 30'd1;
    end
    if (elapsed_next < fmcc_pkg::ELAPSED_MAX) begin
      elapsed_next = elapsed_next + 8'd1;
    end

    res.motor_run = drive_next;
    res.cycle_phase = phase_next;
    res.feed_started = started;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fmcc_pkg::PH_STOPPED;
      since_cycle_ms <= '0;
      debounce_elapsed <= '0;
      last_fed_day <= fmcc_pkg::NO_FED_DAY;
      last_fed_hour <= fmcc_pkg::NO_FED_HOUR;
      drive_on <= 1'b0;
    end else if (en) begin
      phase <= phase_next;
      since_cycle_ms <= since_next;
      debounce_elapsed <= elapsed_next;
      last_fed_day <= last_day_next;
      last_fed_hour <= last_hour_next;
      drive_on <= drive_next;
    end
  end

endmodule

### src/feeder_motor_cycle_controller_unit.sv
// Feeder motor cycle controller.
// Input channel (in_valid/in_ready): one beat per millisecond tick carrying
// switch_level (0 pressed), weekday and hour_of_day.
// Output channel (out_valid/out_ready): one beat per input beat, carrying
// motor_run, cycle_phase (0 on switch, 1 running, 2 stopped, 3 debouncing)
// and feed_started.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; index 0..5 selects interval_mode_on, schedule_mode_on,
// interval_hours, schedule_count, schedule_table, debounce_ms. Higher
// indexes are dropped. Write only while no tick is in flight.
// Path: input beat to result beat through the input register, then the
// phase update into the result register. Throughput: one beat per cycle
// while out_ready stays high; the phase and counter update is combinational.
// Reset: phase stopped, counters cleared, no day/hour fed yet, debounce_ms
// 30, other config registers and valid flags 0; data registers not reset.
// Stall: when out_ready is low the result holds, one more beat fills the
// input register, then in_ready drops until the result is taken.
module feeder_motor_cycle_controller_unit #(
  parameter int unsigned SCHEDULE_SLOTS = fmcc_pkg::SCHEDULE_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        switch_level,
  input  logic [2:0]  weekday,
  input  logic [4:0]  hour_of_day,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        motor_run,
  output logic [1:0]  cycle_phase,
  output logic        feed_started,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  fmcc_pkg::cfg_t cfg;
  logic [SCHEDULE_SLOTS*fmcc_pkg::ENTRY_W-1:0] schedule_table;
  fmcc_pkg::res_t res;

  logic       in_full;
  logic       in_sw;
  logic [2:0] in_day;
  logic [4:0] in_hour;
  logic       advance;
  logic       in_take;

  assign cfg_ready = 1'b1;
  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign in_take = in_valid && in_ready;

  fmcc_cfg #(.SCHEDULE_SLOTS(SCHEDULE_SLOTS)) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (cfg_valid && cfg_ready),
    .wr_index       (cfg_index),
    .wr_data        (cfg_data),
    .cfg            (cfg),
    .schedule_table (schedule_table)
  );

  fmcc_core #(.SCHEDULE_SLOTS(SCHEDULE_SLOTS)) u_core (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .cfg            (cfg),
    .schedule_table (schedule_table),
    .sw             (in_sw),
    .day            (in_day),
    .hour           (in_hour),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sw <= switch_level;
      in_day <= weekday;
      in_hour <= hour_of_day;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      motor_run <= res.motor_run;
      cycle_phase <= res.cycle_phase;
      feed_started <= res.feed_started;
    end
  end

  a_drive_matches_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_run == (cycle_phase != fmcc_pkg::PH_STOPPED)))
    else $error("motor drive disagrees with cycle phase");

  a_start_drives: assert property (@(posedge clk) disable iff (rst)
    (out_valid && feed_started) |-> (motor_run && cycle_phase != fmcc_pkg::PH_STOPPED))
    else $error("feed start without motor drive");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_sw) && $stable(in_day)
                               && $stable(in_hour)))
    else $error("pending tick lost from input register");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(motor_run)
                                   && $stable(cycle_phase) && $stable(feed_started)))
    else $error("result overwritten while stalled");

endmodule

### dv/feeder_motor_cycle_controller_unit_tb.sv
module feeder_motor_cycle_controller_unit_tb;

  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic           is_cfg;
    logic [2:0]     idx;
    logic [63:0]    data;
    logic           sw;
    logic [2:0]     day;
    logic [4:0]     hour;
    logic           known;
    fmcc_pkg::res_t want;
  } feed_step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        switch_level = 1'b1;
  logic [2:0]  weekday = 3'd0;
  logic [4:0]  hour_of_day = 5'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        motor_run;
  logic [1:0]  cycle_phase;
  logic        feed_started;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_data = 64'd0;

  // predictor copy of the registers
  logic        c_interval_on = 1'b0;
  logic        c_sched_on = 1'b0;
  logic [7:0]  c_interval_hours = 8'd0;
  logic [3:0]  c_sched_count = 4'd0;
  logic [63:0] c_sched_table = 64'd0;
  logic [7:0]  c_debounce_ms = fmcc_pkg::DEBOUNCE_RESET;

  // predictor copy of the cycle state
  logic [1:0]  cyc_phase = fmcc_pkg::PH_STOPPED;
  logic [29:0] ms_since_cycle = 30'd0;
  logic [7:0]  release_ticks = 8'd0;
  logic [2:0]  fed_day = fmcc_pkg::NO_FED_DAY;
  logic [4:0]  fed_hour = fmcc_pkg::NO_FED_HOUR;
  logic        drive = 1'b0;

  fmcc_pkg::res_t feed_results[$];
  feed_step_t     plan[$];
  int             mismatches = 0;
  int             result_beats = 0;
  int             burst_left = 0;
  int             quiet_cycles = 0;
  int             stall_tick = 0;

  feeder_motor_cycle_controller_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .switch_level (switch_level),
    .weekday      (weekday),
    .hour_of_day  (hour_of_day),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .motor_run    (motor_run),
    .cycle_phase  (cycle_phase),
    .feed_started (feed_started),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] data);
    case (idx)
      fmcc_pkg::REG_INTERVAL_MODE_ON: c_interval_on = data[0];
      fmcc_pkg::REG_SCHEDULE_MODE_ON: c_sched_on = data[0];
      fmcc_pkg::REG_INTERVAL_HOURS:   c_interval_hours = data[7:0];
      fmcc_pkg::REG_SCHEDULE_COUNT:   c_sched_count = data[3:0];
      fmcc_pkg::REG_SCHEDULE_TABLE:   c_sched_table = data;
      fmcc_pkg::REG_DEBOUNCE_MS:      c_debounce_ms = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic fmcc_pkg::res_t step_feeder(input logic sw, input logic [2:0] day,
                                                 input logic [4:0] hour);
    logic           started;
    int unsigned    slots;
    logic [7:0]     entry;
    logic [63:0]    need;
    fmcc_pkg::res_t r;
    started = 1'b0;
    if (cyc_phase == fmcc_pkg::PH_STOPPED) begin
      need = 64'(c_interval_hours) * 64'(fmcc_pkg::MS_PER_HOUR);
      if (c_interval_on && 64'(ms_since_cycle) >= need) begin
        drive = 1'b1;
        cyc_phase = fmcc_pkg::PH_RUNNING;
        started = 1'b1;
      end
      if (c_sched_on) begin
        slots = (c_sched_count > fmcc_pkg::SCHEDULE_SLOTS_DEFAULT)
                ? fmcc_pkg::SCHEDULE_SLOTS_DEFAULT : c_sched_count;
        for (int i = 0; i < slots; i++) begin
          entry = c_sched_table[8*i +: 8];
          if (day == entry[2:0] && hour == entry[7:3] &&
              !(day == fed_day && hour == fed_hour)) begin
            drive = 1'b1;
            cyc_phase = fmcc_pkg::PH_RUNNING;
            started = 1'b1;
            fed_day = day;
            fed_hour = hour;
          end
        end
      end
    end
    if (cyc_phase == fmcc_pkg::PH_RUNNING && !sw) cyc_phase = fmcc_pkg::PH_ON_SWITCH;
    if (cyc_phase == fmcc_pkg::PH_ON_SWITCH && sw) begin
      release_ticks = 8'd0;
      cyc_phase = fmcc_pkg::PH_DEBOUNCE;
    end
    if (cyc_phase == fmcc_pkg::PH_DEBOUNCE &&
        (release_ticks > c_debounce_ms || release_ticks == fmcc_pkg::ELAPSED_MAX)) begin
      if (sw) begin
        drive = 1'b0;
        ms_since_cycle = 30'd0;
        cyc_phase = fmcc_pkg::PH_STOPPED;
      end else begin
        cyc_phase = fmcc_pkg::PH_ON_SWITCH;
      end
    end
    if (ms_since_cycle < fmcc_pkg::SINCE_MAX) ms_since_cycle = ms_since_cycle + 30'd1;
    if (release_ticks < fmcc_pkg::ELAPSED_MAX) release_ticks = release_ticks + 8'd1;
    r.motor_run = drive;
    r.cycle_phase = cyc_phase;
    r.feed_started = started;
    return r;
  endfunction

  function automatic logic [63:0] with_junk(input logic [63:0] v, input int w);
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    return ({$urandom, $urandom} & ~m) | (v & m);
  endfunction

  function automatic feed_step_t cfg_step(input logic [2:0] idx, input logic [63:0] data);
    feed_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic feed_step_t tick_step(input logic sw, input logic [2:0] day,
                                           input logic [4:0] hour);
    feed_step_t s;
    s = '0;
    s.sw = sw;
    s.day = day;
    s.hour = hour;
    return s;
  endfunction

  function automatic feed_step_t tick_known(input logic sw, input logic [2:0] day,
                                            input logic [4:0] hour, input logic m,
                                            input logic [1:0] p, input logic st);
    feed_step_t s;
    s = tick_step(sw, day, hour);
    s.known = 1'b1;
    s.want.motor_run = m;
    s.want.cycle_phase = p;
    s.want.feed_started = st;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH beat %0d %s: got %0d want %0d", result_beats, what, got, want);
    mismatches++;
  endtask

  task automatic send_tick(input logic sw, input logic [2:0] day, input logic [4:0] hour,
                           input logic known, input fmcc_pkg::res_t want);
    int             gap;
    fmcc_pkg::res_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    switch_level <= sw;
    weekday <= day;
    hour_of_day <= hour;
    do @(posedge clk); while (!in_ready);
    pred = step_feeder(sw, day, hour);
    feed_results.push_back(known ? want : pred);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    in_valid <= 1'b0;
    while (feed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[8:7])
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 1) == 0);
      2'd2:    out_ready <= (stall_tick[2:0] != 3'd0);
      default: out_ready <= stall_tick[3];
    endcase
  end

  always @(posedge clk) begin : check_results
    fmcc_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      if (feed_results.size() == 0) begin
        report_mismatch("unexpected beat, cycle_phase", cycle_phase, -1);
      end else begin
        want = feed_results.pop_front();
        if (motor_run !== want.motor_run)
          report_mismatch("motor_run", motor_run, want.motor_run);
        if (cycle_phase !== want.cycle_phase)
          report_mismatch("cycle_phase", cycle_phase, want.cycle_phase);
        if (feed_started !== want.feed_started)
          report_mismatch("feed_started", feed_started, want.feed_started);
      end
      result_beats++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          n_items;
    int          k;
    int          sw_hold;
    logic        sw_level;
    logic [2:0]  day;
    logic [4:0]  hour;
    logic        ion;
    logic [7:0]  hrs;
    logic [7:0]  dbm;

    plan.push_back(tick_known(1'b1, 3'd0, 5'd0, 1'b0, fmcc_pkg::PH_STOPPED, 1'b0));
    plan.push_back(tick_known(1'b0, 3'd6, 5'd23, 1'b0, fmcc_pkg::PH_STOPPED, 1'b0));
    plan.push_back(cfg_step(fmcc_pkg::REG_INTERVAL_HOURS, 64'd0));
    plan.push_back(cfg_step(fmcc_pkg::REG_DEBOUNCE_MS, 64'd0));
    plan.push_back(cfg_step(fmcc_pkg::REG_INTERVAL_MODE_ON, 64'd1));
    plan.push_back(tick_known(1'b1, 3'd3, 5'd12, 1'b1, fmcc_pkg::PH_RUNNING, 1'b1));
    plan.push_back(tick_known(1'b0, 3'd3, 5'd12, 1'b1, fmcc_pkg::PH_ON_SWITCH, 1'b0));
    plan.push_back(tick_known(1'b1, 3'd3, 5'd12, 1'b1, fmcc_pkg::PH_DEBOUNCE, 1'b0));
    plan.push_back(tick_known(1'b1, 3'd3, 5'd12, 1'b0, fmcc_pkg::PH_STOPPED, 1'b0));
    plan.push_back(tick_known(1'b0, 3'd3, 5'd12, 1'b1, fmcc_pkg::PH_ON_SWITCH, 1'b1));
    plan.push_back(tick_known(1'b1, 3'd3, 5'd12, 1'b1, fmcc_pkg::PH_DEBOUNCE, 1'b0));
    plan.push_back(tick_known(1'b0, 3'd3, 5'd12, 1'b1, fmcc_pkg::PH_ON_SWITCH, 1'b0));
    plan.push_back(tick_step(1'b1, 3'd3, 5'd12));
    plan.push_back(tick_step(1'b1, 3'd3, 5'd12));
    plan.push_back(cfg_step(fmcc_pkg::REG_INTERVAL_HOURS, 64'd255));
    plan.push_back(cfg_step(3'd6, '1));
    plan.push_back(cfg_step(3'd7, '1));
    plan.push_back(tick_known(1'b1, 3'd3, 5'd12, 1'b0, fmcc_pkg::PH_STOPPED, 1'b0));
    plan.push_back(cfg_step(fmcc_pkg::REG_INTERVAL_MODE_ON, 64'd0));
    plan.push_back(cfg_step(fmcc_pkg::REG_SCHEDULE_COUNT, 64'd15));
    plan.push_back(cfg_step(fmcc_pkg::REG_SCHEDULE_TABLE, 64'hFF00_0000_0000_002A));
    plan.push_back(cfg_step(fmcc_pkg::REG_SCHEDULE_MODE_ON, 64'd1));
    plan.push_back(tick_known(1'b1, 3'd7, 5'd31, 1'b0, fmcc_pkg::PH_STOPPED, 1'b0));
    plan.push_back(tick_known(1'b1, 3'd2, 5'd5, 1'b1, fmcc_pkg::PH_RUNNING, 1'b1));
    plan.push_back(tick_step(1'b0, 3'd2, 5'd5));
    plan.push_back(tick_step(1'b1, 3'd2, 5'd5));
    plan.push_back(tick_step(1'b1, 3'd2, 5'd5));
    plan.push_back(tick_known(1'b1, 3'd2, 5'd5, 1'b0, fmcc_pkg::PH_STOPPED, 1'b0));
    plan.push_back(tick_known(1'b1, 3'd7, 5'd31, 1'b1, fmcc_pkg::PH_RUNNING, 1'b1));
    plan.push_back(tick_step(1'b0, 3'd7, 5'd31));
    plan.push_back(tick_step(1'b1, 3'd7, 5'd31));
    plan.push_back(tick_step(1'b1, 3'd7, 5'd31));
    plan.push_back(cfg_step(fmcc_pkg::REG_INTERVAL_HOURS, 64'd0));
    plan.push_back(cfg_step(fmcc_pkg::REG_INTERVAL_MODE_ON, 64'd1));
    plan.push_back(tick_known(1'b1, 3'd0, 5'd0, 1'b1, fmcc_pkg::PH_RUNNING, 1'b1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_reg(plan[i].idx, plan[i].data);
      else
        send_tick(plan[i].sw, plan[i].day, plan[i].hour, plan[i].known, plan[i].want);
    end

    sw_level = 1'b1;
    sw_hold = 0;
    day = 3'd0;
    hour = 5'd0;
    for (int ph = 0; ph < 8; ph++) begin
      dbm = (ph == 0) ? 8'd255 : (ph == 1) ? 8'd0 : 8'($urandom_range(0, 40));
      ion = (ph < 2) ? 1'b1 : 1'($urandom_range(0, 1));
      hrs = (ion && (ph < 2 || $urandom_range(0, 3) != 0)) ? 8'd0
                                                          : 8'($urandom_range(1, 255));
      write_reg(fmcc_pkg::REG_INTERVAL_MODE_ON, with_junk(64'(ion), 1));
      write_reg(fmcc_pkg::REG_SCHEDULE_MODE_ON,
                with_junk(64'($urandom_range(0, 3) != 0), 1));
      write_reg(fmcc_pkg::REG_INTERVAL_HOURS, with_junk(64'(hrs), 8));
      write_reg(fmcc_pkg::REG_SCHEDULE_COUNT,
                with_junk(64'((ph == 2) ? 0 : $urandom_range(0, 15)), 4));
      write_reg(fmcc_pkg::REG_SCHEDULE_TABLE, {$urandom, $urandom});
      write_reg(fmcc_pkg::REG_DEBOUNCE_MS, with_junk(64'(dbm), 8));
      if ($urandom_range(0, 1) == 1)
        write_reg(3'($urandom_range(6, 7)), {$urandom, $urandom});

      n_items = (ph == 0) ? 300 : $urandom_range(30, 50);
      repeat (n_items) begin
        // hold the switch level for a run, sometimes a one-tick glitch
        if (sw_hold == 0) begin
          sw_level = !sw_level;
          if (sw_level && $urandom_range(0, 1) == 1)
            sw_hold = int'(c_debounce_ms) + $urandom_range(2, 10);
          else
            sw_hold = $urandom_range(0, 5);
        end else begin
          sw_hold--;
        end
        case ($urandom_range(0, 3))
          0, 1: begin
            k = $urandom_range(0, 7);
            day = c_sched_table[8*k +: 3];
            hour = c_sched_table[8*k+3 +: 5];
          end
          2: ;
          default: begin
            day = 3'($urandom_range(0, 7));
            hour = 5'($urandom_range(0, 31));
          end
        endcase
        send_tick(sw_level, day, hour, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (feed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
